/* hw/rtl/hit_interval_merge_table_defines.svh */
// ----------------------------------------------------------------------------
// hit interval merge table assertion macros
// shared concurrent assertion forms, clocked on clk_i and reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef HIT_INTERVAL_MERGE_TABLE_DEFINES_SVH
`define HIT_INTERVAL_MERGE_TABLE_DEFINES_SVH

// property that holds at every edge
`define HMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define HMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hmt_pkg.sv */
// ----------------------------------------------------------------------------
// hmt_pkg
// types and constants shared by the hit interval merge table modules
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  localparam int FIELD_TIME_W  = 32;
  localparam int FIELD_COUNT_W = 5;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ORDER,
    ST_SCAN,
    ST_PLACE,
    ST_RESP,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic drain;
  } time_ctrl_t;

endpackage

/* hw/rtl/hmt_mem.sv */
// ----------------------------------------------------------------------------
// hmt_mem
// interval store, one write and one registered read port
// ----------------------------------------------------------------------------
module hmt_mem #(
  parameter int ADDR_WIDTH = 5,
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_WIDTH-1:0] wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_WIDTH-1:0] rd_addr_i,
  output logic [DATA_WIDTH-1:0] rd_data_o
);

  logic [DATA_WIDTH-1:0] mem_q [2**ADDR_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* hw/rtl/hmt_time.sv */
// ----------------------------------------------------------------------------
// hmt_time
// event base register and saturating absolute time calculation
// ----------------------------------------------------------------------------
module hmt_time #(
  parameter int TIME_WIDTH = hmt_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hmt_pkg::time_ctrl_t                 ctrl_i,
  input  logic                                primary_i,
  input  logic [hmt_pkg::FIELD_TIME_W-1:0]    rel_lead_i,
  input  logic [hmt_pkg::FIELD_TIME_W-1:0]    rel_trail_i,
  input  logic [hmt_pkg::FIELD_TIME_W-1:0]    event_time_i,
  output logic signed [TIME_WIDTH-1:0]        lead_abs_o,
  output logic signed [TIME_WIDTH-1:0]        trail_abs_o
);

  localparam int SumW = ((TIME_WIDTH > hmt_pkg::FIELD_TIME_W) ?
                         TIME_WIDTH : hmt_pkg::FIELD_TIME_W) + 1;

  function automatic logic [TIME_WIDTH-1:0] sat_tw(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = {{(SumW-TIME_WIDTH+1){1'b0}}, {(TIME_WIDTH-1){1'b1}}};
    lo = {{(SumW-TIME_WIDTH+1){1'b1}}, {(TIME_WIDTH-1){1'b0}}};
    if (v > hi) begin
      return hi[TIME_WIDTH-1:0];
    end
    if (v < lo) begin
      return lo[TIME_WIDTH-1:0];
    end
    return v[TIME_WIDTH-1:0];
  endfunction

  logic signed [TIME_WIDTH-1:0]           base_q, base_d;
  logic [hmt_pkg::FIELD_TIME_W-1:0]       rel_lead_q, rel_trail_q;
  logic signed [SumW-1:0]                 base_ext, ev_ext, lead_sum, trail_sum;

  assign ev_ext    = SumW'($signed(event_time_i));
  assign base_ext  = SumW'(base_q);
  assign lead_sum  = base_ext + SumW'($signed(rel_lead_q));
  assign trail_sum = base_ext + SumW'($signed(rel_trail_q));

  assign lead_abs_o  = $signed(sat_tw(lead_sum));
  assign trail_abs_o = $signed(sat_tw(trail_sum));

  always_comb begin
    base_d = base_q;
    if (ctrl_i.accept && ctrl_i.drain) begin
      base_d = '0;
    end else if (ctrl_i.accept && primary_i) begin
      base_d = $signed(sat_tw(ev_ext));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && !ctrl_i.drain) begin
      rel_lead_q  <= rel_lead_i;
      rel_trail_q <= rel_trail_i;
    end
  end

endmodule

/* hw/rtl/hmt_seq.sv */
// ----------------------------------------------------------------------------
// hmt_seq
// sequencer: merge scan, ordered copy between banks, drain and result register
// ----------------------------------------------------------------------------
`include "hit_interval_merge_table_defines.svh"

module hmt_seq #(
  parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_WIDTH  = hmt_pkg::TIME_WIDTH_DEF,
  parameter int ADDR_WIDTH  = $clog2(TABLE_DEPTH) + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  hmt_pkg::op_e                        op_i,
  output hmt_pkg::time_ctrl_t                 time_ctrl_o,
  input  logic signed [TIME_WIDTH-1:0]        lead_abs_i,
  input  logic signed [TIME_WIDTH-1:0]        trail_abs_i,
  output logic                                mem_wr_en_o,
  output logic [ADDR_WIDTH-1:0]               mem_wr_addr_o,
  output logic [2*TIME_WIDTH-1:0]             mem_wr_data_o,
  output logic                                mem_rd_en_o,
  output logic [ADDR_WIDTH-1:0]               mem_rd_addr_o,
  input  logic [2*TIME_WIDTH-1:0]             mem_rd_data_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [hmt_pkg::FIELD_TIME_W-1:0]    lead_o,
  output logic [hmt_pkg::FIELD_TIME_W-1:0]    trail_o,
  output logic [hmt_pkg::FIELD_COUNT_W-1:0]   count_o,
  output logic                                overflow_o,
  output logic                                empty_o,
  output logic                                last_o
);

  localparam int IdxW = ADDR_WIDTH - 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int ExtW = (TIME_WIDTH > hmt_pkg::FIELD_TIME_W) ?
                        TIME_WIDTH : hmt_pkg::FIELD_TIME_W;
  localparam int CxtW = (CntW > hmt_pkg::FIELD_COUNT_W) ? CntW : hmt_pkg::FIELD_COUNT_W;

  function automatic logic [hmt_pkg::FIELD_TIME_W-1:0] time_out(
    input logic signed [TIME_WIDTH-1:0] v
  );
    logic signed [ExtW-1:0] e;
    e = ExtW'(v);
    return e[hmt_pkg::FIELD_TIME_W-1:0];
  endfunction

  function automatic logic [hmt_pkg::FIELD_COUNT_W-1:0] count_out(input logic [CntW-1:0] v);
    logic [CxtW-1:0] e;
    e = CxtW'(v);
    return e[hmt_pkg::FIELD_COUNT_W-1:0];
  endfunction

  hmt_pkg::state_e state_q, state_d;

  logic                          bank_q, bank_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               rd_idx_q, rd_idx_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]               proc_idx_q, proc_idx_d;
  logic [CntW-1:0]               wr_idx_q, wr_idx_d;
  logic                          ins_done_q, ins_done_d;
  logic [TABLE_DEPTH-1:0]        merged_q, merged_d;
  logic signed [TIME_WIDTH-1:0]  a_q, a_d, b_q, b_d;
  logic [CntW-1:0]               resp_cnt_q, resp_cnt_d;
  logic                          resp_ovf_q, resp_ovf_d;
  logic                          resp_empty_q, resp_empty_d;

  logic                                 out_vld_q, out_vld_d;
  logic [hmt_pkg::FIELD_TIME_W-1:0]     out_lead_q, out_lead_d;
  logic [hmt_pkg::FIELD_TIME_W-1:0]     out_trail_q, out_trail_d;
  logic [hmt_pkg::FIELD_COUNT_W-1:0]    out_cnt_q, out_cnt_d;
  logic                                 out_ovf_q, out_ovf_d;
  logic                                 out_empty_q, out_empty_d;
  logic                                 out_last_q, out_last_d;

  logic signed [TIME_WIDTH-1:0]  ent_lead, ent_trail;
  logic                          accept, out_free, pass_run, pass_done, hold;
  logic                          goes_before, overlap, table_full;
  logic                          place_hold, drain_done;
  logic [CntW-1:0]               new_count;

  assign ent_lead  = $signed(mem_rd_data_i[TIME_WIDTH-1:0]);
  assign ent_trail = $signed(mem_rd_data_i[2*TIME_WIDTH-1:TIME_WIDTH]);

  assign s_ready_o   = (state_q == hmt_pkg::ST_IDLE);
  assign accept      = s_valid_i && s_ready_o;
  assign out_free    = !out_vld_q || m_ready_i;
  assign table_full  = (count_q == CntW'(TABLE_DEPTH));
  assign pass_run    = (state_q == hmt_pkg::ST_SCAN) || (state_q == hmt_pkg::ST_PLACE) ||
                       (state_q == hmt_pkg::ST_DRAIN);
  assign pass_done   = pass_run && (rd_idx_q == count_q) && !rd_vld_q;
  assign goes_before = (ent_lead > a_q) || ((ent_lead == a_q) && (ent_trail > b_q));
  assign overlap     = (a_q < ent_trail) && (ent_lead < b_q);
  assign new_count   = wr_idx_q + CntW'(!ins_done_q);

  // new interval goes out first, the entry just read is held to the next cycle
  assign hold = rd_vld_q &&
    (((state_q == hmt_pkg::ST_PLACE) && !merged_q[proc_idx_q] && !ins_done_q && goes_before) ||
     ((state_q == hmt_pkg::ST_DRAIN) && !out_free));

  assign place_hold = (state_q == hmt_pkg::ST_PLACE) && hold;
  assign drain_done = (state_q == hmt_pkg::ST_DRAIN) && pass_done;

  assign mem_rd_en_o   = pass_run && (rd_idx_q < count_q) && !hold;
  assign mem_rd_addr_o = {bank_q, rd_idx_q[IdxW-1:0]};
  assign mem_wr_addr_o = {~bank_q, wr_idx_q[IdxW-1:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      hmt_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == hmt_pkg::OP_DRAIN) begin
            state_d = (count_q == '0) ? hmt_pkg::ST_RESP : hmt_pkg::ST_DRAIN;
          end else begin
            state_d = table_full ? hmt_pkg::ST_RESP : hmt_pkg::ST_CALC;
          end
        end
      end
      hmt_pkg::ST_CALC:  state_d = hmt_pkg::ST_ORDER;
      hmt_pkg::ST_ORDER: state_d = hmt_pkg::ST_SCAN;
      hmt_pkg::ST_SCAN: begin
        if (pass_done) state_d = hmt_pkg::ST_PLACE;
      end
      hmt_pkg::ST_PLACE: begin
        if (pass_done) state_d = hmt_pkg::ST_RESP;
      end
      hmt_pkg::ST_RESP: begin
        if (out_free) state_d = hmt_pkg::ST_IDLE;
      end
      hmt_pkg::ST_DRAIN: begin
        if (pass_done) state_d = hmt_pkg::ST_IDLE;
      end
      default: state_d = hmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bank_d       = bank_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = rd_vld_q;
    proc_idx_d   = proc_idx_q;
    wr_idx_d     = wr_idx_q;
    ins_done_d   = ins_done_q;
    merged_d     = merged_q;
    a_d          = a_q;
    b_d          = b_q;
    resp_cnt_d   = resp_cnt_q;
    resp_ovf_d   = resp_ovf_q;
    resp_empty_d = resp_empty_q;
    out_vld_d    = out_vld_q && !m_ready_i;
    out_lead_d   = out_lead_q;
    out_trail_d  = out_trail_q;
    out_cnt_d    = out_cnt_q;
    out_ovf_d    = out_ovf_q;
    out_empty_d  = out_empty_q;
    out_last_d   = out_last_q;
    time_ctrl_o  = '0;
    mem_wr_en_o  = 1'b0;
    mem_wr_data_o = {ent_trail, ent_lead};

    // shared read walk
    if (mem_rd_en_o) begin
      rd_idx_d   = rd_idx_q + CntW'(1);
      proc_idx_d = rd_idx_q[IdxW-1:0];
      rd_vld_d   = 1'b1;
    end else if (!hold) begin
      rd_vld_d = 1'b0;
    end

    case (state_q)
      hmt_pkg::ST_IDLE: begin
        if (accept) begin
          time_ctrl_o.accept = 1'b1;
          time_ctrl_o.drain  = (op_i == hmt_pkg::OP_DRAIN);
          rd_idx_d = '0;
          rd_vld_d = 1'b0;
          if (op_i == hmt_pkg::OP_DRAIN) begin
            resp_cnt_d   = '0;
            resp_ovf_d   = 1'b0;
            resp_empty_d = 1'b1;
          end else begin
            resp_cnt_d   = count_q;
            resp_ovf_d   = 1'b1;
            resp_empty_d = 1'b0;
          end
        end
      end
      hmt_pkg::ST_CALC: begin
        a_d = lead_abs_i;
        b_d = trail_abs_i;
      end
      hmt_pkg::ST_ORDER: begin
        if (a_q > b_q) begin
          a_d = b_q;
          b_d = a_q;
        end
        rd_idx_d = '0;
        rd_vld_d = 1'b0;
      end
      hmt_pkg::ST_SCAN: begin
        if (rd_vld_q) begin
          merged_d[proc_idx_q] = overlap;
          if (overlap) begin
            a_d = (ent_lead < a_q) ? ent_lead : a_q;
            b_d = (ent_trail > b_q) ? ent_trail : b_q;
          end
        end
        if (pass_done) begin
          rd_idx_d   = '0;
          wr_idx_d   = '0;
          ins_done_d = 1'b0;
        end
      end
      hmt_pkg::ST_PLACE: begin
        if (rd_vld_q && !merged_q[proc_idx_q]) begin
          mem_wr_en_o = 1'b1;
          wr_idx_d    = wr_idx_q + CntW'(1);
          if (!ins_done_q && goes_before) begin
            mem_wr_data_o = {b_q, a_q};
            ins_done_d    = 1'b1;
          end
        end
        if (pass_done) begin
          if (!ins_done_q) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {b_q, a_q};
          end
          count_d      = new_count;
          bank_d       = ~bank_q;
          resp_cnt_d   = new_count;
          resp_ovf_d   = 1'b0;
          resp_empty_d = 1'b0;
        end
      end
      hmt_pkg::ST_RESP: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_lead_d  = '0;
          out_trail_d = '0;
          out_cnt_d   = count_out(resp_cnt_q);
          out_ovf_d   = resp_ovf_q;
          out_empty_d = resp_empty_q;
          out_last_d  = 1'b1;
        end
      end
      hmt_pkg::ST_DRAIN: begin
        if (rd_vld_q && out_free) begin
          out_vld_d   = 1'b1;
          out_lead_d  = time_out(ent_lead);
          out_trail_d = time_out(ent_trail);
          out_cnt_d   = count_out(count_q);
          out_ovf_d   = 1'b0;
          out_empty_d = 1'b0;
          out_last_d  = ((CntW'(proc_idx_q) + CntW'(1)) == count_q);
        end
        if (pass_done) begin
          count_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hmt_pkg::ST_IDLE;
      bank_q     <= 1'b0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      wr_idx_q   <= '0;
      ins_done_q <= 1'b0;
      merged_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      bank_q     <= bank_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      rd_vld_q   <= rd_vld_d;
      wr_idx_q   <= wr_idx_d;
      ins_done_q <= ins_done_d;
      merged_q   <= merged_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q   <= proc_idx_d;
    a_q          <= a_d;
    b_q          <= b_d;
    resp_cnt_q   <= resp_cnt_d;
    resp_ovf_q   <= resp_ovf_d;
    resp_empty_q <= resp_empty_d;
    out_lead_q   <= out_lead_d;
    out_trail_q  <= out_trail_d;
    out_cnt_q    <= out_cnt_d;
    out_ovf_q    <= out_ovf_d;
    out_empty_q  <= out_empty_d;
    out_last_q   <= out_last_d;
  end

  assign m_valid_o  = out_vld_q;
  assign lead_o     = out_lead_q;
  assign trail_o    = out_trail_q;
  assign count_o    = out_cnt_q;
  assign overflow_o = out_ovf_q;
  assign empty_o    = out_empty_q;
  assign last_o     = out_last_q;

  `HMT_ASSERT_ALWAYS(a_count_range, count_q <= CntW'(TABLE_DEPTH), "count beyond table depth")
  `HMT_ASSERT_IMPL(a_wr_in_place, mem_wr_en_o, state_q == hmt_pkg::ST_PLACE, "write outside place")
  `HMT_ASSERT_NEXT(a_hold_inserts, place_hold, ins_done_q && rd_vld_q, "held entry lost")
  `HMT_ASSERT_NEXT(a_drain_clears, drain_done, count_q == '0, "drain left entries")

endmodule

/* hw/rtl/hit_interval_merge_table.sv */
// ----------------------------------------------------------------------------
// hit_interval_merge_table
// time-ordered table of disjoint pulse intervals with merge on insert
// ----------------------------------------------------------------------------
//   s_axis carries one request: insert (tuser[0] = 0) or drain (tuser[0] = 1).
//   an insert turns its relative lead/trail into absolute times against the
//   event base (reloaded first when tuser[1] is set), merges every stored
//   interval it strictly overlaps and keeps the table ordered by lead.
//   each insert gives one result with the new count, or overflow when full.
//   a drain clears the base, gives every stored interval in order, tlast on the
//   final one, then clears the table; an empty table gives one is_empty result.
//   an insert makes a scan walk, then a place walk, over the interval memory (one
//   read and one write port), with a hold when it lands ahead of a kept entry, and
//   answers from ST_RESP; a full table answers from ST_RESP without a walk. a drain
//   gives one result per cycle while m_axis is ready; after it the next request is
//   taken in the cycle after the walk ends. one request is worked at a time.
//   a stalled m_axis holds the result and pauses a drain walk without losing
//   entries. after reset the table is empty and the base is zero; no clearing pass.
// ----------------------------------------------------------------------------
module hit_interval_merge_table #(
  parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_WIDTH  = hmt_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rel_lead, rel_trail, event_time
  input  logic [hmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation, is_primary
  input  logic [hmt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // lead_out, trail_out, entry_count, zero pad
  output logic [hmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // overflow, is_empty
  output logic [hmt_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int AddrW = $clog2(TABLE_DEPTH) + 1;
  localparam int TW    = hmt_pkg::FIELD_TIME_W;
  localparam int PadW  = hmt_pkg::OUT_TDATA_W - 2 * TW - hmt_pkg::FIELD_COUNT_W;

  hmt_pkg::time_ctrl_t             time_ctrl;
  logic signed [TIME_WIDTH-1:0]    lead_abs, trail_abs;
  logic                            mem_wr_en, mem_rd_en;
  logic [AddrW-1:0]                mem_wr_addr, mem_rd_addr;
  logic [2*TIME_WIDTH-1:0]         mem_wr_data, mem_rd_data;
  logic [TW-1:0]                   lead_out, trail_out;
  logic [hmt_pkg::FIELD_COUNT_W-1:0] entry_count;
  logic                            overflow, is_empty;

  hmt_time #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_time (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (time_ctrl),
    .primary_i    (s_axis_tuser[1]),
    .rel_lead_i   (s_axis_tdata[TW-1:0]),
    .rel_trail_i  (s_axis_tdata[2*TW-1:TW]),
    .event_time_i (s_axis_tdata[3*TW-1:2*TW]),
    .lead_abs_o   (lead_abs),
    .trail_abs_o  (trail_abs)
  );

  hmt_mem #(
    .ADDR_WIDTH (AddrW),
    .DATA_WIDTH (2 * TIME_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  hmt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .ADDR_WIDTH  (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .op_i          (hmt_pkg::op_e'(s_axis_tuser[0])),
    .time_ctrl_o   (time_ctrl),
    .lead_abs_i    (lead_abs),
    .trail_abs_i   (trail_abs),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .lead_o        (lead_out),
    .trail_o       (trail_out),
    .count_o       (entry_count),
    .overflow_o    (overflow),
    .empty_o       (is_empty),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, entry_count, trail_out, lead_out};
  assign m_axis_tuser = {is_empty, overflow};

endmodule
